@@ rtl/core/sft_pkg.sv @@
`timescale 1ns / 1ps

package sft_pkg;

   localparam int SFT_COORD_W        = 32;
   localparam int SFT_DIFF_W         = SFT_COORD_W + 1;
   localparam int SFT_ANGLE_W        = 16;
   localparam int SFT_CORDIC_W       = 32;
   localparam int SFT_TRIG_SHIFT     = 6;
   localparam int SFT_TRIG_W         = SFT_CORDIC_W - SFT_TRIG_SHIFT;
   localparam int SFT_PROD_W         = SFT_DIFF_W + SFT_TRIG_W;
   localparam int SFT_SUM_W          = SFT_PROD_W + 1;
   localparam int SFT_FRAC_SHIFT     = 24;
   localparam int SFT_ROT_W          = SFT_SUM_W - SFT_FRAC_SHIFT;
   localparam int SFT_OFS_W          = SFT_ROT_W + 1;
   localparam int SFT_ATAN_ENTRIES   = 24;
   localparam int SFT_ROTATION_STEPS = 16;
   localparam int SFT_NUM_COORDS     = 4;

   // 0.60725 in Q2.30, pre-scales the vector so the cordic gain cancels
   localparam logic signed [SFT_CORDIC_W-1:0] SFT_CORDIC_GAIN = 32'sh26DD3B6A;
   localparam logic signed [SFT_CORDIC_W-1:0] SFT_TRIG_ROUND  =
      SFT_CORDIC_W'(1) << (SFT_TRIG_SHIFT - 1);
   localparam logic [SFT_SUM_W-1:0] SFT_ROT_ROUND =
      SFT_SUM_W'(1) << (SFT_FRAC_SHIFT - 1);
   localparam logic [SFT_ANGLE_W-1:0] SFT_OCTANT = SFT_ANGLE_W'(1) << (SFT_ANGLE_W - 3);

   // unit vector in Q.24 plus generous cordic error margin
   localparam logic signed [SFT_TRIG_W-1:0] SFT_TRIG_LIMIT =
      SFT_TRIG_W'((1 << SFT_FRAC_SHIFT) + (1 << 16));

   // atan(2^-i) in units of 2^-32 turn
   localparam logic signed [SFT_CORDIC_W-1:0] SFT_ATAN [SFT_ATAN_ENTRIES] = '{
      32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4,
      32'sh028B0D43, 32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55,
      32'sh0028BE53, 32'sh00145F2F, 32'sh000A2F98, 32'sh000517CC,
      32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA, 32'sh0000517D,
      32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518,
      32'sh0000028C, 32'sh00000146, 32'sh000000A3, 32'sh00000051
   };

   typedef enum logic {
      SFT_TO_LOCAL = 1'b0,
      SFT_TO_WORLD = 1'b1
   } sft_mode_type;

   typedef enum logic [1:0] {
      SFT_QUAD_0   = 2'd0,
      SFT_QUAD_90  = 2'd1,
      SFT_QUAD_180 = 2'd2,
      SFT_QUAD_270 = 2'd3
   } sft_quad_type;

   typedef struct packed {
      sft_mode_type                   mode;
      logic signed [SFT_COORD_W-1:0]  ofs_x;
      logic signed [SFT_COORD_W-1:0]  ofs_y;
      logic                           last;
   } sft_meta_type;

   typedef struct packed {
      sft_meta_type                   meta;
      logic signed [SFT_DIFF_W-1:0]   p0_x;
      logic signed [SFT_DIFF_W-1:0]   p0_y;
      logic signed [SFT_DIFF_W-1:0]   p1_x;
      logic signed [SFT_DIFF_W-1:0]   p1_y;
   } sft_payload_type;

   typedef struct packed {
      logic signed [SFT_CORDIC_W-1:0] x;
      logic signed [SFT_CORDIC_W-1:0] y;
      logic signed [SFT_CORDIC_W-1:0] z;
      sft_quad_type                   quad;
   } sft_cordic_type;

   typedef struct packed {
      sft_payload_type                payload;
      logic signed [SFT_TRIG_W-1:0]   cos_v;
      logic signed [SFT_TRIG_W-1:0]   sin_v;
   } sft_rot_in_type;

endpackage

@@ rtl/core/sft_cordic_stage.sv @@
`timescale 1ns / 1ps

module sft_cordic_stage import sft_pkg::*; #(
   parameter int STEP = 0
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  sft_cordic_type  in_cordic,
   input  sft_payload_type in_payload,
   output logic            out_valid,
   output sft_cordic_type  out_cordic,
   output sft_payload_type out_payload
);

   localparam logic signed [SFT_CORDIC_W-1:0] ATAN_STEP = SFT_ATAN[STEP];

   logic signed [SFT_CORDIC_W-1:0] x_shift;
   logic signed [SFT_CORDIC_W-1:0] y_shift;
   sft_cordic_type                 cordic_in;
   sft_cordic_type                 cordic_ff;
   sft_payload_type                payload_ff;
   logic                           valid_ff;

   always_comb begin
      x_shift        = $signed(in_cordic.x) >>> STEP;
      y_shift        = $signed(in_cordic.y) >>> STEP;
      cordic_in      = in_cordic;
      // rotate toward zero residual angle
      if (!in_cordic.z[SFT_CORDIC_W-1]) begin
         cordic_in.x = in_cordic.x - y_shift;
         cordic_in.y = in_cordic.y + x_shift;
         cordic_in.z = in_cordic.z - ATAN_STEP;
      end else begin
         cordic_in.x = in_cordic.x + y_shift;
         cordic_in.y = in_cordic.y - x_shift;
         cordic_in.z = in_cordic.z + ATAN_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      cordic_ff  <= cordic_in;
      payload_ff <= in_payload;
   end

   assign out_valid   = valid_ff;
   assign out_cordic  = cordic_ff;
   assign out_payload = payload_ff;

endmodule

@@ rtl/core/sft_rotate.sv @@
`timescale 1ns / 1ps

module sft_rotate import sft_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  sft_rot_in_type                in_rot,
   output logic                          out_valid,
   output logic signed [SFT_COORD_W-1:0] out_start_x,
   output logic signed [SFT_COORD_W-1:0] out_start_y,
   output logic signed [SFT_COORD_W-1:0] out_end_x,
   output logic signed [SFT_COORD_W-1:0] out_end_y,
   output logic                          out_last
);

   logic signed [SFT_DIFF_W-1:0]  pnt_x [2];
   logic signed [SFT_DIFF_W-1:0]  pnt_y [2];
   logic signed [SFT_PROD_W-1:0]  prod_a_in [SFT_NUM_COORDS];
   logic signed [SFT_PROD_W-1:0]  prod_b_in [SFT_NUM_COORDS];
   logic signed [SFT_PROD_W-1:0]  prod_a_ff [SFT_NUM_COORDS];
   logic signed [SFT_PROD_W-1:0]  prod_b_ff [SFT_NUM_COORDS];
   logic signed [SFT_SUM_W-1:0]   sum_wide  [SFT_NUM_COORDS];
   logic signed [SFT_ROT_W-1:0]   rot_ff    [SFT_NUM_COORDS];
   logic signed [SFT_OFS_W-1:0]   total     [SFT_NUM_COORDS];
   logic signed [SFT_COORD_W-1:0] coord_in  [SFT_NUM_COORDS];
   logic signed [SFT_COORD_W-1:0] coord_ff  [SFT_NUM_COORDS];
   sft_meta_type                  mul_meta_ff;
   sft_meta_type                  sum_meta_ff;
   logic                          last_ff;
   logic                          mul_valid_ff;
   logic                          sum_valid_ff;
   logic                          out_valid_ff;

   assign pnt_x[0] = in_rot.payload.p0_x;
   assign pnt_y[0] = in_rot.payload.p0_y;
   assign pnt_x[1] = in_rot.payload.p1_x;
   assign pnt_y[1] = in_rot.payload.p1_y;

   // even coords are x: px*c - py*s, odd are y: px*s + py*c
   for (genvar k = 0; k < 2; k++) begin : g_point
      assign prod_a_in[2*k]   = pnt_x[k] * in_rot.cos_v;
      assign prod_b_in[2*k]   = pnt_y[k] * in_rot.sin_v;
      assign prod_a_in[2*k+1] = pnt_x[k] * in_rot.sin_v;
      assign prod_b_in[2*k+1] = pnt_y[k] * in_rot.cos_v;
   end

   for (genvar j = 0; j < SFT_NUM_COORDS; j++) begin : g_coord
      logic signed [SFT_SUM_W-1:0] ext_a;
      logic signed [SFT_SUM_W-1:0] ext_b;
      logic signed [SFT_OFS_W-1:0] ofs_ext;

      assign ext_a = {prod_a_ff[j][SFT_PROD_W-1], prod_a_ff[j]};
      assign ext_b = {prod_b_ff[j][SFT_PROD_W-1], prod_b_ff[j]};
      if (j % 2 == 0) begin : g_x
         assign sum_wide[j] = ext_a - ext_b + $signed(SFT_ROT_ROUND);
         assign ofs_ext     = SFT_OFS_W'(sum_meta_ff.ofs_x);
      end else begin : g_y
         assign sum_wide[j] = ext_a + ext_b + $signed(SFT_ROT_ROUND);
         assign ofs_ext     = SFT_OFS_W'(sum_meta_ff.ofs_y);
      end

      always_comb begin
         if (sum_meta_ff.mode == SFT_TO_WORLD) begin
            total[j] = {rot_ff[j][SFT_ROT_W-1], rot_ff[j]} + ofs_ext;
         end else begin
            total[j] = {rot_ff[j][SFT_ROT_W-1], rot_ff[j]};
         end
         // clamp when the bits above the sign disagree with it
         if (total[j][SFT_OFS_W-1:SFT_COORD_W-1] == '0 ||
             total[j][SFT_OFS_W-1:SFT_COORD_W-1] == '1) begin
            coord_in[j] = total[j][SFT_COORD_W-1:0];
         end else if (total[j][SFT_OFS_W-1]) begin
            coord_in[j] = {1'b1, {(SFT_COORD_W-1){1'b0}}};
         end else begin
            coord_in[j] = {1'b0, {(SFT_COORD_W-1){1'b1}}};
         end
      end

      always_ff @(posedge clock) begin
         prod_a_ff[j] <= prod_a_in[j];
         prod_b_ff[j] <= prod_b_in[j];
         rot_ff[j]    <= sum_wide[j][SFT_SUM_W-1:SFT_FRAC_SHIFT];
         coord_ff[j]  <= coord_in[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         sum_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= in_valid;
         sum_valid_ff <= mul_valid_ff;
         out_valid_ff <= sum_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      mul_meta_ff <= in_rot.payload.meta;
      sum_meta_ff <= mul_meta_ff;
      last_ff     <= sum_meta_ff.last;
   end

   assign out_valid   = out_valid_ff;
   assign out_start_x = coord_ff[0];
   assign out_start_y = coord_ff[1];
   assign out_end_x   = coord_ff[2];
   assign out_end_y   = coord_ff[3];
   assign out_last    = last_ff;

endmodule

@@ rtl/core/segment_frame_transform.sv @@
`timescale 1ns / 1ps

// channel   ports                          handshake
// --------  -----------------------------  ---------------------------------
// request   req_type .. req_last_segment   taken when start & !busy
// response  rsp_out_start_x .. last mark   rsp_valid strobe, one cycle
//
// one word in per cycle; each word passes through the cordic chain, one
// register per step, plus angle setup, quadrant fold, multiply, sum and
// offset/saturate stages
// busy never rises; the pipeline has no stall path since results cannot be held
// synchronous reset clears the valid bits only, data registers are not reset

module segment_frame_transform import sft_pkg::*; #(
   parameter int ROTATION_STEPS = SFT_ROTATION_STEPS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_type,
   input  logic signed [SFT_COORD_W-1:0] req_start_x,
   input  logic signed [SFT_COORD_W-1:0] req_start_y,
   input  logic signed [SFT_COORD_W-1:0] req_end_x,
   input  logic signed [SFT_COORD_W-1:0] req_end_y,
   input  logic        [SFT_ANGLE_W-1:0] req_turn_angle,
   input  logic signed [SFT_COORD_W-1:0] req_pivot_x,
   input  logic signed [SFT_COORD_W-1:0] req_pivot_y,
   input  logic                          req_last_segment,
   output logic                          rsp_valid,
   output logic signed [SFT_COORD_W-1:0] rsp_out_start_x,
   output logic signed [SFT_COORD_W-1:0] rsp_out_start_y,
   output logic signed [SFT_COORD_W-1:0] rsp_out_end_x,
   output logic signed [SFT_COORD_W-1:0] rsp_out_end_y,
   output logic                          rsp_out_last_segment
);

   localparam int NUM_STEPS = (ROTATION_STEPS < SFT_ATAN_ENTRIES) ?
                              ROTATION_STEPS : SFT_ATAN_ENTRIES;
   localparam int LATENCY   = NUM_STEPS + 5;

   sft_mode_type                  mode;
   logic        [SFT_ANGLE_W-1:0] angle;
   logic        [SFT_ANGLE_W-1:0] angle_bias;
   logic        [SFT_ANGLE_W-1:0] resid;
   sft_quad_type                  quad;
   logic signed [SFT_DIFF_W-1:0]  ofs_x_ext;
   logic signed [SFT_DIFF_W-1:0]  ofs_y_ext;
   sft_cordic_type                cordic_in;
   sft_payload_type               payload_in;
   sft_cordic_type                cordic_ff;
   sft_payload_type               payload_ff;
   logic                          valid_ff;

   logic            [NUM_STEPS:0] valid_pipe;
   sft_cordic_type                cordic_pipe  [NUM_STEPS+1];
   sft_payload_type               payload_pipe [NUM_STEPS+1];

   logic signed [SFT_CORDIC_W-1:0] cos_full;
   logic signed [SFT_CORDIC_W-1:0] sin_full;
   logic signed [SFT_CORDIC_W-1:0] cos_round;
   logic signed [SFT_CORDIC_W-1:0] sin_round;
   sft_rot_in_type                 fold_in;
   sft_rot_in_type                 fold_ff;
   logic                           fold_valid_ff;

   assign busy = 1'b0;

   // angle setup and, in to-local mode, pivot removal
   always_comb begin
      mode       = sft_mode_type'(req_type);
      angle      = (mode == SFT_TO_WORLD) ? req_turn_angle :
                   SFT_ANGLE_W'(0) - req_turn_angle;
      angle_bias = angle + SFT_OCTANT;
      quad       = sft_quad_type'(angle_bias[SFT_ANGLE_W-1 -: 2]);
      resid      = angle - {angle_bias[SFT_ANGLE_W-1 -: 2], {(SFT_ANGLE_W-2){1'b0}}};

      cordic_in.x    = SFT_CORDIC_GAIN;
      cordic_in.y    = '0;
      cordic_in.z    = {resid, {(SFT_CORDIC_W-SFT_ANGLE_W){1'b0}}};
      cordic_in.quad = quad;

      ofs_x_ext = (mode == SFT_TO_WORLD) ? '0 : SFT_DIFF_W'(req_pivot_x);
      ofs_y_ext = (mode == SFT_TO_WORLD) ? '0 : SFT_DIFF_W'(req_pivot_y);

      payload_in.meta.mode  = mode;
      payload_in.meta.ofs_x = req_pivot_x;
      payload_in.meta.ofs_y = req_pivot_y;
      payload_in.meta.last  = req_last_segment;
      payload_in.p0_x       = SFT_DIFF_W'(req_start_x) - ofs_x_ext;
      payload_in.p0_y       = SFT_DIFF_W'(req_start_y) - ofs_y_ext;
      payload_in.p1_x       = SFT_DIFF_W'(req_end_x) - ofs_x_ext;
      payload_in.p1_y       = SFT_DIFF_W'(req_end_y) - ofs_y_ext;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      cordic_ff  <= cordic_in;
      payload_ff <= payload_in;
   end

   assign valid_pipe[0]   = valid_ff;
   assign cordic_pipe[0]  = cordic_ff;
   assign payload_pipe[0] = payload_ff;

   for (genvar i = 0; i < NUM_STEPS; i++) begin : g_cordic
      sft_cordic_stage #(
         .STEP(i)
      ) u_stage (
         .clock      (clock),
         .reset      (reset),
         .in_valid   (valid_pipe[i]),
         .in_cordic  (cordic_pipe[i]),
         .in_payload (payload_pipe[i]),
         .out_valid  (valid_pipe[i+1]),
         .out_cordic (cordic_pipe[i+1]),
         .out_payload(payload_pipe[i+1])
      );
   end

   // quadrant fold and rounding to Q.24
   always_comb begin
      unique case (cordic_pipe[NUM_STEPS].quad)
         SFT_QUAD_0: begin
            cos_full = cordic_pipe[NUM_STEPS].x;
            sin_full = cordic_pipe[NUM_STEPS].y;
         end
         SFT_QUAD_90: begin
            cos_full = -cordic_pipe[NUM_STEPS].y;
            sin_full = cordic_pipe[NUM_STEPS].x;
         end
         SFT_QUAD_180: begin
            cos_full = -cordic_pipe[NUM_STEPS].x;
            sin_full = -cordic_pipe[NUM_STEPS].y;
         end
         SFT_QUAD_270: begin
            cos_full = cordic_pipe[NUM_STEPS].y;
            sin_full = -cordic_pipe[NUM_STEPS].x;
         end
         default: begin
            cos_full = cordic_pipe[NUM_STEPS].x;
            sin_full = cordic_pipe[NUM_STEPS].y;
         end
      endcase
      cos_round       = cos_full + SFT_TRIG_ROUND;
      sin_round       = sin_full + SFT_TRIG_ROUND;
      fold_in.payload = payload_pipe[NUM_STEPS];
      fold_in.cos_v   = cos_round[SFT_CORDIC_W-1:SFT_TRIG_SHIFT];
      fold_in.sin_v   = sin_round[SFT_CORDIC_W-1:SFT_TRIG_SHIFT];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_valid_ff <= 1'b0;
      end else begin
         fold_valid_ff <= valid_pipe[NUM_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      fold_ff <= fold_in;
   end

   sft_rotate u_rotate (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (fold_valid_ff),
      .in_rot     (fold_ff),
      .out_valid  (rsp_valid),
      .out_start_x(rsp_out_start_x),
      .out_start_y(rsp_out_start_y),
      .out_end_x  (rsp_out_end_x),
      .out_end_y  (rsp_out_end_y),
      .out_last   (rsp_out_last_segment)
   );

`ifndef SYNTH
   a_word_delivered: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("accepted word produced no response");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("response without matching request");

   a_last_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_last_segment == $past(req_last_segment, LATENCY)))
      else $error("last-segment mark out of step with its word");

   a_trig_bounded: assert property (@(posedge clock) disable iff (reset)
      fold_valid_ff |-> (fold_ff.cos_v <= SFT_TRIG_LIMIT) &&
                        (fold_ff.cos_v >= -SFT_TRIG_LIMIT) &&
                        (fold_ff.sin_v <= SFT_TRIG_LIMIT) &&
                        (fold_ff.sin_v >= -SFT_TRIG_LIMIT))
      else $error("sine or cosine outside unit range");
`endif

endmodule
